### design/crt_pkg.sv
`default_nettype none
package crt_pkg;

  // table sizes
  localparam int unsigned ROUTE_ENTRIES = 32;
  localparam int unsigned BCAST_ENTRIES = 16;
  localparam int unsigned MAX_RESULTS   = 32;

  // field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CALL_W   = 56;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned FLAGS_W  = 2;
  localparam int unsigned STATUS_W = 2;

  // derived widths
  localparam int unsigned ROUTE_AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned BCAST_AW = (BCAST_ENTRIES > 1) ? $clog2(BCAST_ENTRIES) : 1;
  localparam int unsigned ROUTE_CW = $clog2(ROUTE_ENTRIES + 1);
  localparam int unsigned BCAST_CW = $clog2(BCAST_ENTRIES + 1);
  localparam int unsigned SCAN_CW  = (ROUTE_CW > BCAST_CW) ? ROUTE_CW : BCAST_CW;
  localparam int unsigned N_CW     = $clog2(MAX_RESULTS + 1);

  // route memory word: {broadcast mark, port, ip, callsign}
  localparam int unsigned RT_W = 1 + PORT_W + IP_W + CALL_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD_ROUTE = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_BCAST = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd2;
  localparam logic [OP_W-1:0] OP_BTEST     = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST      = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  // callsign normalization masks
  localparam logic [7:0] NAME_AND = 8'hfe;
  localparam logic [7:0] SSID_AND = 8'h1e;
  localparam logic [7:0] SSID_OR  = 8'h60;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                via_default;
    logic [IP_W-1:0]     route_ip;
    logic [PORT_W-1:0]   route_port;
    logic                is_broadcast;
  } res_t;

  // clear the low bit of each name byte, force the ssid byte pattern
  function automatic logic [CALL_W-1:0] norm_call(input logic [CALL_W-1:0] c);
    logic [CALL_W-1:0] r;
    for (int b = 1; b < 7; b++) begin
      r[b*8 +: 8] = c[b*8 +: 8] & NAME_AND;
    end
    r[7:0] = (c[7:0] & SSID_AND) | SSID_OR;
    return r;
  endfunction

endpackage
`default_nettype wire

### design/crt_in_if.sv
`default_nettype none
interface crt_in_if;
  logic                             valid;
  logic                             ready;
  logic [crt_pkg::OP_W-1:0]         op;
  logic [crt_pkg::CALL_W-1:0]       callsign;
  logic [crt_pkg::IP_W-1:0]         ip_addr;
  logic [crt_pkg::PORT_W-1:0]       dst_port;
  logic [crt_pkg::FLAGS_W-1:0]      route_flags;

  modport source (output valid, op, callsign, ip_addr, dst_port, route_flags, input ready);
  modport sink   (input valid, op, callsign, ip_addr, dst_port, route_flags, output ready);
endinterface
`default_nettype wire

### design/crt_out_if.sv
`default_nettype none
interface crt_out_if;
  logic                             valid;
  logic                             ready;
  logic [crt_pkg::STATUS_W-1:0]     status;
  logic                             via_default;
  logic [crt_pkg::IP_W-1:0]         route_ip;
  logic [crt_pkg::PORT_W-1:0]       route_port;
  logic                             is_broadcast;
  logic                             last;

  modport source (output valid, status, via_default, route_ip, route_port, is_broadcast, last,
                  input ready);
  modport sink   (input valid, status, via_default, route_ip, route_port, is_broadcast, last,
                  output ready);
endinterface
`default_nettype wire

### design/callsign_route_table.sv
// Adds and unused ops: the result goes through the result register into the output register.
// Lookup and broadcast test walk the entries one per cycle through a registered read port:
// a hit answers once its entry is compared, a miss after the walk ends, and the default route
// is read from memory in a further state. Listing holds each marked route back until the walk
// reaches the next one; output stalls delay every result, and a new item waits for the last result.
// Reset clears counts and the default route; memory contents need no clearing pass.
`default_nettype none
module callsign_route_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  crt_in_if.sink    req_i,
  crt_out_if.source rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DEF  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [crt_pkg::SCAN_CW-1:0]     idx_q, idx_d;
  logic                            rd_vld_q, rd_vld_d;
  logic [crt_pkg::N_CW-1:0]        n_q, n_d;
  logic                            pend_q, pend_d;
  logic [crt_pkg::ROUTE_CW-1:0]    route_count_q, route_count_d;
  logic [crt_pkg::BCAST_CW-1:0]    bcast_count_q, bcast_count_d;
  logic                            def_vld_q, def_vld_d;
  logic [crt_pkg::ROUTE_AW-1:0]    def_slot_q, def_slot_d;
  logic                            out_vld_q, out_vld_d;

  logic [crt_pkg::OP_W-1:0]        op_q, op_d;
  logic [crt_pkg::CALL_W-1:0]      call_q, call_d;
  crt_pkg::res_t                   res_q, res_d;
  crt_pkg::res_t                   out_q, out_d;
  logic                            out_last_q, out_last_d;

  logic                            rt_we, rt_re;
  logic [crt_pkg::ROUTE_AW-1:0]    rt_raddr;
  logic [crt_pkg::RT_W-1:0]        rt_wdata, rt_rdata;
  logic                            bc_we, bc_re;
  logic [crt_pkg::CALL_W-1:0]      bc_rdata;

  logic [crt_pkg::CALL_W-1:0]      rt_call;
  logic [crt_pkg::IP_W-1:0]        rt_ip;
  logic [crt_pkg::PORT_W-1:0]      rt_port;
  logic                            rt_mark;
  logic [crt_pkg::CALL_W-1:0]      in_call;
  logic [crt_pkg::SCAN_CW-1:0]     scan_limit;
  logic                            out_free, stall, done, accept;

  // route and broadcast memories
  crt_ram #(
    .WIDTH (crt_pkg::RT_W),
    .DEPTH (crt_pkg::ROUTE_ENTRIES),
    .ADDR_W(crt_pkg::ROUTE_AW)
  ) u_route_ram (
    .clk_i  (clk_i),
    .we_i   (rt_we),
    .waddr_i(route_count_q[crt_pkg::ROUTE_AW-1:0]),
    .wdata_i(rt_wdata),
    .re_i   (rt_re),
    .raddr_i(rt_raddr),
    .rdata_o(rt_rdata)
  );

  crt_ram #(
    .WIDTH (crt_pkg::CALL_W),
    .DEPTH (crt_pkg::BCAST_ENTRIES),
    .ADDR_W(crt_pkg::BCAST_AW)
  ) u_bcast_ram (
    .clk_i  (clk_i),
    .we_i   (bc_we),
    .waddr_i(bcast_count_q[crt_pkg::BCAST_AW-1:0]),
    .wdata_i(in_call),
    .re_i   (bc_re),
    .raddr_i(idx_q[crt_pkg::BCAST_AW-1:0]),
    .rdata_o(bc_rdata)
  );

  // unpack route word
  assign rt_call = rt_rdata[crt_pkg::CALL_W-1:0];
  assign rt_ip   = rt_rdata[crt_pkg::CALL_W +: crt_pkg::IP_W];
  assign rt_port = rt_rdata[crt_pkg::CALL_W + crt_pkg::IP_W +: crt_pkg::PORT_W];
  assign rt_mark = rt_rdata[crt_pkg::RT_W-1];

  assign in_call  = crt_pkg::norm_call(req_i.callsign);
  assign rt_wdata = {req_i.route_flags[1], req_i.dst_port, req_i.ip_addr, in_call};

  assign accept     = req_i.valid && (state_q == S_IDLE);
  assign out_free   = !out_vld_q || rsp_o.ready;
  assign scan_limit = (op_q == crt_pkg::OP_BTEST) ? crt_pkg::SCAN_CW'(bcast_count_q)
                                                  : crt_pkg::SCAN_CW'(route_count_q);

  // sequencer
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    rd_vld_d      = rd_vld_q;
    n_d           = n_q;
    pend_d        = pend_q;
    route_count_d = route_count_q;
    bcast_count_d = bcast_count_q;
    def_vld_d     = def_vld_q;
    def_slot_d    = def_slot_q;
    op_d          = op_q;
    call_d        = call_q;
    res_d         = res_q;
    out_d         = out_q;
    out_last_d    = out_last_q;
    out_vld_d     = out_vld_q && !rsp_o.ready;
    rt_we         = 1'b0;
    rt_re         = 1'b0;
    rt_raddr      = idx_q[crt_pkg::ROUTE_AW-1:0];
    bc_we         = 1'b0;
    bc_re         = 1'b0;
    stall         = 1'b0;
    done          = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = req_i.op;
          call_d = in_call;
          res_d  = '0;
          unique case (req_i.op) inside
            crt_pkg::OP_ADD_ROUTE: begin
              if (route_count_q == crt_pkg::ROUTE_CW'(crt_pkg::ROUTE_ENTRIES)) begin
                res_d.status = crt_pkg::ST_FULL;
              end else begin
                rt_we         = 1'b1;
                route_count_d = route_count_q + crt_pkg::ROUTE_CW'(1);
                if (req_i.route_flags[0]) begin
                  def_vld_d  = 1'b1;
                  def_slot_d = route_count_q[crt_pkg::ROUTE_AW-1:0];
                end
              end
              state_d = S_EMIT;
            end
            crt_pkg::OP_ADD_BCAST: begin
              if (bcast_count_q == crt_pkg::BCAST_CW'(crt_pkg::BCAST_ENTRIES)) begin
                res_d.status = crt_pkg::ST_FULL;
              end else begin
                bc_we         = 1'b1;
                bcast_count_d = bcast_count_q + crt_pkg::BCAST_CW'(1);
              end
              state_d = S_EMIT;
            end
            crt_pkg::OP_LOOKUP, crt_pkg::OP_BTEST, crt_pkg::OP_LIST: begin
              idx_d    = '0;
              rd_vld_d = 1'b0;
              n_d      = '0;
              pend_d   = 1'b0;
              state_d  = S_SCAN;
            end
            default: begin
              res_d.status = crt_pkg::ST_NONE;
              state_d      = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // compare the entry held on the registered read port
        if (rd_vld_q) begin
          case (op_q)
            crt_pkg::OP_LOOKUP: begin
              if (rt_call == call_q) begin
                res_d              = '0;
                res_d.status       = crt_pkg::ST_OK;
                res_d.route_ip     = rt_ip;
                res_d.route_port   = rt_port;
                state_d            = S_EMIT;
                done               = 1'b1;
              end
            end
            crt_pkg::OP_BTEST: begin
              if (bc_rdata == call_q) begin
                res_d              = '0;
                res_d.status       = crt_pkg::ST_OK;
                res_d.is_broadcast = 1'b1;
                state_d            = S_EMIT;
                done               = 1'b1;
              end
            end
            default: begin
              // listing: hold one route back so the final one can carry last
              if (rt_mark) begin
                if (pend_q && !out_free) begin
                  stall = 1'b1;
                end else begin
                  if (pend_q) begin
                    out_d      = res_q;
                    out_last_d = 1'b0;
                    out_vld_d  = 1'b1;
                  end
                  res_d            = '0;
                  res_d.status     = crt_pkg::ST_OK;
                  res_d.route_ip   = rt_ip;
                  res_d.route_port = rt_port;
                  pend_d           = 1'b1;
                  n_d              = n_q + crt_pkg::N_CW'(1);
                  if (n_q == crt_pkg::N_CW'(crt_pkg::MAX_RESULTS - 1)) begin
                    state_d = S_EMIT;
                    done    = 1'b1;
                  end
                end
              end
            end
          endcase
        end

        // issue the next read, or wrap up once the walk has drained
        if (!stall && !done) begin
          if (idx_q < scan_limit) begin
            if (op_q == crt_pkg::OP_BTEST) begin
              bc_re = 1'b1;
            end else begin
              rt_re = 1'b1;
            end
            idx_d    = idx_q + crt_pkg::SCAN_CW'(1);
            rd_vld_d = 1'b1;
          end else begin
            rd_vld_d = 1'b0;
            if (!rd_vld_q) begin
              if (op_q == crt_pkg::OP_LOOKUP && def_vld_q) begin
                rt_re    = 1'b1;
                rt_raddr = def_slot_q;
                state_d  = S_DEF;
              end else begin
                if (!(op_q == crt_pkg::OP_LIST && pend_q)) begin
                  res_d        = '0;
                  res_d.status = crt_pkg::ST_NONE;
                end
                state_d = S_EMIT;
              end
            end
          end
        end
      end

      S_DEF: begin
        res_d             = '0;
        res_d.status      = crt_pkg::ST_OK;
        res_d.via_default = 1'b1;
        res_d.route_ip    = rt_ip;
        res_d.route_port  = rt_port;
        state_d           = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_d      = res_q;
          out_last_d = 1'b1;
          out_vld_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      rd_vld_q      <= 1'b0;
      n_q           <= '0;
      pend_q        <= 1'b0;
      route_count_q <= '0;
      bcast_count_q <= '0;
      def_vld_q     <= 1'b0;
      def_slot_q    <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      rd_vld_q      <= rd_vld_d;
      n_q           <= n_d;
      pend_q        <= pend_d;
      route_count_q <= route_count_d;
      bcast_count_q <= bcast_count_d;
      def_vld_q     <= def_vld_d;
      def_slot_q    <= def_slot_d;
      out_vld_q     <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    call_q     <= call_d;
    res_q      <= res_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  // ports
  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.via_default  = out_q.via_default;
  assign rsp_o.route_ip     = out_q.route_ip;
  assign rsp_o.route_port   = out_q.route_port;
  assign rsp_o.is_broadcast = out_q.is_broadcast;
  assign rsp_o.last         = out_last_q;

endmodule
`default_nettype wire

### design/crt_ram.sv
`default_nettype none
module crt_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### verif/route_checker.sv
`default_nettype none
module route_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  crt_in_if           req_mon,
  crt_out_if          rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import crt_pkg::*;

  typedef struct packed {
    res_t body;
    logic last;
  } route_answer_t;

  // shadow copy of the tables
  logic [CALL_W-1:0] route_call [ROUTE_ENTRIES];
  logic [IP_W-1:0]   route_ip   [ROUTE_ENTRIES];
  logic [PORT_W-1:0] route_port [ROUTE_ENTRIES];
  logic              route_mark [ROUTE_ENTRIES];
  logic [CALL_W-1:0] bcast_call [BCAST_ENTRIES];
  int unsigned       route_cnt;
  int unsigned       bcast_cnt;
  int unsigned       dflt_slot;
  logic              dflt_valid;

  // answers predicted but not yet seen on the output
  route_answer_t route_answers[$];

  // name bytes lose bit 0, ssid byte keeps bits 4..1 and gets 0x60
  function automatic logic [CALL_W-1:0] canon_call(input logic [CALL_W-1:0] c);
    return (c & {{6{NAME_AND}}, 8'h00}) | {48'h0, (c[7:0] & SSID_AND) | SSID_OR};
  endfunction

  function automatic void push_answer(input logic [STATUS_W-1:0] st, input logic via_dflt,
                                      input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port,
                                      input logic bcast, input logic fin);
    route_answer_t a;
    a.body.status       = st;
    a.body.via_default  = via_dflt;
    a.body.route_ip     = ip;
    a.body.route_port   = port;
    a.body.is_broadcast = bcast;
    a.last              = fin;
    route_answers.push_back(a);
  endfunction

  // update the shadow tables and queue the answers one item causes
  function automatic void predict_answers(input logic [OP_W-1:0] op,
                                          input logic [CALL_W-1:0] raw_call,
                                          input logic [IP_W-1:0] ip,
                                          input logic [PORT_W-1:0] port,
                                          input logic [FLAGS_W-1:0] flags);
    logic [CALL_W-1:0] c;
    int                hit;
    int unsigned       marked;
    int unsigned       listed;
    c      = canon_call(raw_call);
    hit    = -1;
    marked = 0;
    listed = 0;
    case (op)
      OP_ADD_ROUTE: begin
        if (route_cnt >= ROUTE_ENTRIES) begin
          push_answer(ST_FULL, 1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          route_call[route_cnt] = c;
          route_ip[route_cnt]   = ip;
          route_port[route_cnt] = port;
          route_mark[route_cnt] = flags[1];
          if (flags[0]) begin
            dflt_valid = 1'b1;
            dflt_slot  = route_cnt;
          end
          route_cnt++;
          push_answer(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_ADD_BCAST: begin
        if (bcast_cnt >= BCAST_ENTRIES) begin
          push_answer(ST_FULL, 1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          bcast_call[bcast_cnt] = c;
          bcast_cnt++;
          push_answer(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_LOOKUP: begin
        // first match in insertion order wins
        for (int i = 0; i < route_cnt; i++) begin
          if (hit < 0 && route_call[i] == c) hit = i;
        end
        if (hit >= 0) begin
          push_answer(ST_OK, 1'b0, route_ip[hit], route_port[hit], 1'b0, 1'b1);
        end else if (dflt_valid) begin
          push_answer(ST_OK, 1'b1, route_ip[dflt_slot], route_port[dflt_slot], 1'b0, 1'b1);
        end else begin
          push_answer(ST_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_BTEST: begin
        for (int i = 0; i < bcast_cnt; i++) begin
          if (bcast_call[i] == c) hit = i;
        end
        if (hit >= 0) push_answer(ST_OK, 1'b0, '0, '0, 1'b1, 1'b1);
        else push_answer(ST_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
      end
      OP_LIST: begin
        // count first so the final listed route carries last
        for (int i = 0; i < route_cnt; i++) begin
          if (route_mark[i] && marked < MAX_RESULTS) marked++;
        end
        for (int i = 0; i < route_cnt; i++) begin
          if (route_mark[i] && listed < marked) begin
            listed++;
            push_answer(ST_OK, 1'b0, route_ip[i], route_port[i], 1'b0, listed == marked);
          end
        end
        if (marked == 0) push_answer(ST_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
      end
      default: begin
        push_answer(ST_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [IP_W-1:0] want_v,
                                      input logic [IP_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      fail_count_o++;
    end
  endfunction

  // compare one output item against the oldest prediction
  function automatic void check_answer();
    route_answer_t want;
    route_answer_t got;
    got.body.status       = rsp_mon.status;
    got.body.via_default  = rsp_mon.via_default;
    got.body.route_ip     = rsp_mon.route_ip;
    got.body.route_port   = rsp_mon.route_port;
    got.body.is_broadcast = rsp_mon.is_broadcast;
    got.last              = rsp_mon.last;
    checked_o++;
    if (route_answers.size() == 0) begin
      $display("%0t ns: unexpected item, expected none, got status %0h ip %0h port %0h",
               $time, got.body.status, got.body.route_ip, got.body.route_port);
      fail_count_o++;
    end else begin
      want = route_answers.pop_front();
      check_field("status", IP_W'(want.body.status), IP_W'(got.body.status));
      check_field("via_default", IP_W'(want.body.via_default), IP_W'(got.body.via_default));
      check_field("route_ip", want.body.route_ip, got.body.route_ip);
      check_field("route_port", IP_W'(want.body.route_port), IP_W'(got.body.route_port));
      check_field("is_broadcast", IP_W'(want.body.is_broadcast),
                  IP_W'(got.body.is_broadcast));
      check_field("last", IP_W'(want.last), IP_W'(got.last));
    end
  endfunction

  // watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_cnt    = 0;
      bcast_cnt    = 0;
      dflt_slot    = 0;
      dflt_valid   = 1'b0;
      fail_count_o = 0;
      checked_o    = 0;
      route_answers.delete();
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        predict_answers(req_mon.op, req_mon.callsign, req_mon.ip_addr, req_mon.dst_port,
                        req_mon.route_flags);
      end
      if (rsp_mon.valid && rsp_mon.ready) check_answer();
    end
    pending_o = route_answers.size();
  end

endmodule
`default_nettype wire

### verif/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crt_pkg::*;

  // op codes the block does not define
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int unsigned RANDOM_ITEMS   = 410;
  localparam int unsigned SETTLE_CYCLES  = ROUTE_ENTRIES + 8;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // bits that normalization throws away
  localparam logic [CALL_W-1:0] CALL_IGNORED = 56'h01_0101_0101_01e1;
  localparam logic [CALL_W-1:0] CALL_ONES    = '1;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned quiet_cycles = 0;
  int unsigned spare_count  = 0;
  int unsigned op_count [8];

  // callsigns already added, used to build hits and near misses
  logic [CALL_W-1:0] route_pool[$];
  logic [CALL_W-1:0] bcast_pool[$];

  crt_in_if  req_if ();
  crt_out_if rsp_if ();

  callsign_route_table u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  route_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CALL_W-1:0] rand_call();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[CALL_W-1:0];
  endfunction

  // stored callsign with ignored bits scrambled, a one-bit near miss, or a fresh one
  function automatic logic [CALL_W-1:0] probe_call(input bit bcast_side);
    logic [CALL_W-1:0] base;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r >= 80 || (bcast_side && bcast_pool.size() == 0) ||
        (!bcast_side && route_pool.size() == 0)) return rand_call();
    if (bcast_side) base = bcast_pool[$urandom_range(0, bcast_pool.size() - 1)];
    else base = route_pool[$urandom_range(0, route_pool.size() - 1)];
    if (r < 62) return base ^ (rand_call() & CALL_IGNORED);
    return base ^ (56'h2 << (8 * $urandom_range(0, 6)));
  endfunction

  // result side: ready runs and stalls
  initial begin : ready_driver
    int unsigned run_len;
    int unsigned stall_len;
    rsp_if.ready = 1'b0;
    forever begin
      run_len   = $urandom_range(1, 24);
      stall_len = pick_gap();
      repeat (run_len) begin
        @(negedge clk);
        rsp_if.ready <= 1'b1;
      end
      repeat (stall_len) begin
        @(negedge clk);
        rsp_if.ready <= 1'b0;
      end
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CALL_W-1:0] call,
                           input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port,
                           input logic [FLAGS_W-1:0] flags);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.callsign    <= call;
    req_if.ip_addr     <= ip;
    req_if.dst_port    <= port;
    req_if.route_flags <= flags;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    op_count[op]++;
    if (op >= OP_SPARE_FIRST) spare_count++;
    if (op == OP_ADD_ROUTE) route_pool.push_back(call);
    if (op == OP_ADD_BCAST) bcast_pool.push_back(call);
  endtask

  // stop sending and let every predicted item come out
  task automatic settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CALL_W-1:0] call;
    int unsigned       sel;
    req_if.valid       = 1'b0;
    req_if.op          = '0;
    req_if.callsign    = '0;
    req_if.ip_addr     = '0;
    req_if.dst_port    = '0;
    req_if.route_flags = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty tables, spare op codes
    send_item(OP_LOOKUP, rand_call(), '0, '0, '0);
    send_item(OP_BTEST, rand_call(), '0, '0, '0);
    send_item(OP_LIST, '0, '0, '0, '0);
    send_item(OP_SPARE_FIRST, CALL_ONES, '1, '1, '1);
    send_item(OP_SPARE_LAST, '0, '0, '0, '0);
    // extreme routes, the second one default and broadcast with raw ip
    send_item(OP_ADD_ROUTE, CALL_ONES, '1, '1, 2'b00);
    send_item(OP_ADD_ROUTE, '0, '0, '0, 2'b11);
    // normalization makes these match the stored entries
    send_item(OP_LOOKUP, CALL_ONES ^ CALL_IGNORED, '0, '0, '0);
    send_item(OP_LOOKUP, CALL_IGNORED, '1, '1, '1);
    // no match falls back to the default route
    send_item(OP_LOOKUP, 56'h12_3456_789a_bcde, '0, '0, '0);
    // duplicate callsign becomes the newer default, first match still wins
    send_item(OP_ADD_ROUTE, CALL_ONES, 32'h0a00_0001, 16'h0001, 2'b01);
    send_item(OP_LOOKUP, CALL_ONES, '0, '0, '0);
    send_item(OP_LOOKUP, 56'h12_3456_789a_bcde, '0, '0, '0);
    // broadcast table: hit through ignored bits, near miss
    send_item(OP_ADD_BCAST, CALL_ONES, '0, '0, '0);
    send_item(OP_ADD_BCAST, '0, '0, '0, '0);
    send_item(OP_BTEST, CALL_ONES ^ CALL_IGNORED, '0, '0, '0);
    send_item(OP_BTEST, CALL_ONES ^ 56'h2, '0, '0, '0);
    send_item(OP_LIST, '0, '0, '0, '0);
    send_item(OP_ADD_ROUTE, rand_call(), $urandom(), 16'($urandom_range(0, 65535)), 2'b10);
    send_item(OP_LIST, CALL_ONES, '1, '1, '1);
    settle();

    // random mix, tables fill up and later adds get dropped
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) settle();
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
        call = ($urandom_range(0, 3) == 0) ? probe_call(1'b0) : rand_call();
        send_item(OP_ADD_ROUTE, call, $urandom(),
                  ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom()),
                  2'($urandom_range(0, 3)));
      end else if (sel < 34) begin
        call = ($urandom_range(0, 3) == 0) ? probe_call(1'b1) : rand_call();
        send_item(OP_ADD_BCAST, call, $urandom(), 16'($urandom()), 2'($urandom_range(0, 3)));
      end else if (sel < 64) begin
        send_item(OP_LOOKUP, probe_call(1'b0), $urandom(), 16'($urandom()),
                  2'($urandom_range(0, 3)));
      end else if (sel < 84) begin
        send_item(OP_BTEST, probe_call(1'b1), $urandom(), 16'($urandom()),
                  2'($urandom_range(0, 3)));
      end else if (sel < 95) begin
        send_item(OP_LIST, rand_call(), $urandom(), 16'($urandom()), 2'($urandom_range(0, 3)));
      end else begin
        send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), rand_call(), $urandom(),
                  16'($urandom()), 2'($urandom_range(0, 3)));
      end
    end
    settle();

    $display("covered %0d adds, %0d bcast adds, %0d lookups, %0d bcast tests, %0d listings,",
             op_count[OP_ADD_ROUTE], op_count[OP_ADD_BCAST], op_count[OP_LOOKUP],
             op_count[OP_BTEST], op_count[OP_LIST]);
    $display("%0d spare-op items and %0d checked result items, both tables filled past full",
             spare_count, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
